// File: hdl/glrr_pkg.sv
package glrr_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_RATE_RATIO    = 3'd0;
   localparam logic [2:0] CSR_LOOP_WINDOW   = 3'd1;
   localparam logic [2:0] CSR_LOOP_DRAG     = 3'd2;
   localparam logic [2:0] CSR_BASE_START    = 3'd3;
   localparam logic [2:0] CSR_READ_START    = 3'd4;
   localparam logic [2:0] CSR_TOTAL_FRAMES  = 3'd5;
   localparam logic [2:0] CSR_FRAMES_LOADED = 3'd6;
   localparam logic [2:0] CSR_AMPLITUDE     = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // transaction kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   // divider geometry: integer source position over loop window
   localparam int QUOT_W = 32;
   localparam int DIVR_W = 24;

   // reset values of the registers
   localparam logic [23:0] RATE_RESET = 24'd65536;
   localparam logic [15:0] AMP_RESET  = 16'd32768;

   // unity interpolation fraction
   localparam logic [16:0] FRAC_ONE = 17'd65536;

   typedef struct packed {
      logic               req_type;
      logic [13:0]        frame_addr;
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
      logic [23:0]        dst_frame;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
      logic [23:0]        out_dst_frame;
   } rsp_item_type;

   // what rides alongside the divider
   typedef struct packed {
      logic        render;
      logic [13:0] frame_addr;
      logic [15:0] sample_left;
      logic [15:0] sample_right;
      logic [23:0] dst_frame;
      logic [15:0] frac;
   } div_side_type;

endpackage

// File: hdl/glrr_div.sv
module glrr_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [31:0]            in_dividend,
   input  glrr_pkg::div_side_type in_side,
   input  logic [23:0]            divisor,
   output logic                   out_valid,
   output logic [31:0]            out_quot,
   output logic [23:0]            out_rem,
   output glrr_pkg::div_side_type out_side
);

   localparam int STAGES = glrr_pkg::QUOT_W;

   logic                   valid_ff [STAGES];
   logic [31:0]            work_ff  [STAGES];
   logic [23:0]            rem_ff   [STAGES];
   glrr_pkg::div_side_type side_ff  [STAGES];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                   cur_valid;
      logic [31:0]            cur_work;
      logic [23:0]            cur_rem;
      glrr_pkg::div_side_type cur_side;
      logic [24:0]            trial;
      logic [24:0]            diff;
      logic                   qbit;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_work  = in_dividend;
         assign cur_rem   = '0;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_work  = work_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      assign trial = {cur_rem, cur_work[31]};
      assign diff  = trial - {1'b0, divisor};
      assign qbit  = ~diff[24];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= cur_valid;
         end
         work_ff[k] <= {cur_work[30:0], qbit};
         rem_ff[k]  <= qbit ? diff[23:0] : trial[23:0];
         side_ff[k] <= cur_side;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = work_ff[STAGES-1];
   assign out_rem   = rem_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

// File: hdl/grain_loop_resample_reader.sv
// Looping linear-interpolation resampler over a stereo frame store.
// Input: a transaction is taken at a rising edge with start high and busy low;
// busy stays low, so one transaction can be taken every cycle. A load
// transaction writes one stereo frame into the store; a render transaction
// gives a destination frame index and produces one result.
// Output: each render result is shown on rsp_data for one cycle with
// rsp_valid high; the receiver cannot stall, so nothing is held. Loads
// give no result. Order is kept.
// Throughput is one transaction per cycle. The pipeline holds the
// 32-stage restoring divider (one quotient bit per stage) that folds the
// source position into the loop window, plus stages of multiply, clamp,
// store read and rounding. Loads and reads hit the store in the same
// stage, so each render sees exactly the loads taken before it.
// Configuration: csr_we/csr_index/csr_wdata write one register per edge;
// the user must write only while no render is in flight, the block itself does not enforce it.
// Reset (synchronous) clears the pipeline valids and restores register
// defaults; the frame store is not cleared and must be loaded before use.
module grain_loop_resample_reader #(
   parameter int STORE_FRAMES = 16384
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  glrr_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   output glrr_pkg::rsp_item_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int AW = (STORE_FRAMES > 2) ? $clog2(STORE_FRAMES) : 1;
   localparam int NW = $clog2(STORE_FRAMES + 1);
   localparam int CW = (NW > 15) ? NW : 15;

   // configuration registers
   logic [23:0]        rate_ratio_ff;
   logic [23:0]        loop_window_ff;
   logic signed [23:0] loop_drag_ff;
   logic [31:0]        base_start_ff;
   logic [31:0]        read_start_ff;
   logic [31:0]        total_frames_ff;
   logic [14:0]        frames_loaded_ff;
   logic [15:0]        amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ratio_ff    <= glrr_pkg::RATE_RESET;
         loop_window_ff   <= '0;
         loop_drag_ff     <= '0;
         base_start_ff    <= '0;
         read_start_ff    <= '0;
         total_frames_ff  <= '0;
         frames_loaded_ff <= '0;
         amplitude_ff     <= glrr_pkg::AMP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            glrr_pkg::CSR_RATE_RATIO:    rate_ratio_ff    <= csr_wdata[23:0];
            glrr_pkg::CSR_LOOP_WINDOW:   loop_window_ff   <= csr_wdata[23:0];
            glrr_pkg::CSR_LOOP_DRAG:     loop_drag_ff     <= $signed(csr_wdata[23:0]);
            glrr_pkg::CSR_BASE_START:    base_start_ff    <= csr_wdata;
            glrr_pkg::CSR_READ_START:    read_start_ff    <= csr_wdata;
            glrr_pkg::CSR_TOTAL_FRAMES:  total_frames_ff  <= csr_wdata;
            glrr_pkg::CSR_FRAMES_LOADED: frames_loaded_ff <= csr_wdata[14:0];
            glrr_pkg::CSR_AMPLITUDE:     amplitude_ff     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic        loop_on;
   logic [23:0] divisor;
   assign loop_on = (loop_window_ff >= 24'd2);
   assign divisor = loop_on ? loop_window_ff : 24'd1;
   assign busy    = 1'b0;

   // stage a: capture transaction
   logic                  a_valid_ff;
   glrr_pkg::req_item_type a_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      a_item_ff <= req_data;
   end

   // stage b: source position in q.16
   logic                   b_valid_ff;
   glrr_pkg::req_item_type b_item_ff;
   logic [47:0]            b_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_item_ff <= a_item_ff;
      b_pos_ff  <= 48'(a_item_ff.dst_frame) * 48'(rate_ratio_ff);
   end

   // divider: wraps and offset in window (divisor one when not looping)
   glrr_pkg::div_side_type b_side;
   logic                   d_valid;
   logic [31:0]            d_quot;
   logic [23:0]            d_rem;
   glrr_pkg::div_side_type d_side;

   always_comb begin
      b_side.render       = (b_item_ff.req_type == glrr_pkg::REQ_RENDER);
      b_side.frame_addr   = b_item_ff.frame_addr;
      b_side.sample_left  = b_item_ff.sample_left;
      b_side.sample_right = b_item_ff.sample_right;
      b_side.dst_frame    = b_item_ff.dst_frame;
      b_side.frac         = b_pos_ff[15:0];
   end

   glrr_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (b_valid_ff),
      .in_dividend (b_pos_ff[47:16]),
      .in_side     (b_side),
      .divisor     (divisor),
      .out_valid   (d_valid),
      .out_quot    (d_quot),
      .out_rem     (d_rem),
      .out_side    (d_side)
   );

   // stage c: window drag product
   logic                   c_valid_ff;
   logic signed [56:0]     c_prod_ff;
   logic [31:0]            c_quot_ff;
   logic [23:0]            c_rem_ff;
   glrr_pkg::div_side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= d_valid;
      end
      c_prod_ff <= 57'($signed({1'b0, d_quot})) * 57'(loop_drag_ff);
      c_quot_ff <= d_quot;
      c_rem_ff  <= d_rem;
      c_side_ff <= d_side;
   end

   // stage e: window start, floored at zero; straight position when not looping
   logic signed [57:0]     e_sum;
   logic                   e_valid_ff;
   logic [56:0]            e_start_ff;
   logic [32:0]            e_nl_ff;
   logic [23:0]            e_rem_ff;
   glrr_pkg::div_side_type e_side_ff;

   assign e_sum = $signed({26'b0, base_start_ff}) + $signed({c_prod_ff[56], c_prod_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= c_valid_ff;
      end
      e_start_ff <= e_sum[57] ? 57'd0 : e_sum[56:0];
      e_nl_ff    <= {1'b0, base_start_ff} + {1'b0, c_quot_ff};
      e_rem_ff   <= c_rem_ff;
      e_side_ff  <= c_side_ff;
   end

   // stage f: keep the window inside the file
   logic [57:0]            f_end;
   logic signed [33:0]     f_alt;
   logic                   f_valid_ff;
   logic [31:0]            f_start_ff;
   logic [32:0]            f_nl_ff;
   logic [23:0]            f_rem_ff;
   glrr_pkg::div_side_type f_side_ff;

   assign f_end = {1'b0, e_start_ff} + {34'b0, loop_window_ff};
   assign f_alt = $signed({2'b0, total_frames_ff}) - $signed({10'b0, loop_window_ff})
                  - 34'sd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      if (f_end >= {26'b0, total_frames_ff}) begin
         f_start_ff <= f_alt[33] ? 32'd0 : f_alt[31:0];
      end else begin
         f_start_ff <= e_start_ff[31:0];
      end
      f_nl_ff   <= e_nl_ff;
      f_rem_ff  <= e_rem_ff;
      f_side_ff <= e_side_ff;
   end

   // stage g: source frame
   logic                   g_valid_ff;
   logic [32:0]            g_src_ff;
   glrr_pkg::div_side_type g_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
      g_src_ff  <= loop_on ? ({1'b0, f_start_ff} + {9'b0, f_rem_ff}) : f_nl_ff;
      g_side_ff <= f_side_ff;
   end

   // stage h: frame relative to the store
   logic                   h_valid_ff;
   logic signed [33:0]     h_local_ff;
   glrr_pkg::div_side_type h_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else begin
         h_valid_ff <= g_valid_ff;
      end
      h_local_ff <= $signed({1'b0, g_src_ff}) - $signed({2'b0, read_start_ff});
      h_side_ff  <= g_side_ff;
   end

   // stage m: store write for loads, neighbor read for renders
   logic [CW-1:0] fl_ext;
   logic [CW-1:0] n_frames;
   logic          m_neg;
   logic          m_past;
   logic [AW-1:0] m_i0;
   logic [AW-1:0] m_i1;
   logic [16:0]   m_frac;
   logic          m_wr_ok;
   logic [AW-1:0] m_wr_addr;

   always_comb begin
      fl_ext = CW'(frames_loaded_ff);
      if (fl_ext < CW'(2)) begin
         n_frames = CW'(2);
      end else if (fl_ext > CW'(STORE_FRAMES)) begin
         n_frames = CW'(STORE_FRAMES);
      end else begin
         n_frames = fl_ext;
      end
      m_neg  = h_local_ff[33];
      m_past = ~m_neg && ({1'b0, h_local_ff[32:0]} >= 34'(n_frames - CW'(1)));
      if (m_neg) begin
         m_i0   = '0;
         m_frac = '0;
      end else if (m_past) begin
         m_i0   = AW'(n_frames - CW'(2));
         m_frac = glrr_pkg::FRAC_ONE;
      end else begin
         m_i0   = h_local_ff[AW-1:0];
         m_frac = {1'b0, h_side_ff.frac};
      end
      m_i1      = m_i0 + AW'(1);
      m_wr_ok   = (32'(h_side_ff.frame_addr) < 32'(STORE_FRAMES));
      m_wr_addr = AW'(h_side_ff.frame_addr);
   end

   logic [31:0] store_mem [STORE_FRAMES];
   logic        m_valid_ff;
   logic [31:0] m_rd0_ff;
   logic [31:0] m_rd1_ff;
   logic [16:0] m_frac_ff;
   logic [23:0] m_dst_ff;

   always_ff @(posedge clock) begin
      if (h_valid_ff && !h_side_ff.render && m_wr_ok) begin
         store_mem[m_wr_addr] <= {h_side_ff.sample_right, h_side_ff.sample_left};
      end
      m_rd0_ff <= store_mem[m_i0];
      m_rd1_ff <= store_mem[m_i1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= h_valid_ff & h_side_ff.render;
      end
      m_frac_ff <= m_frac;
      m_dst_ff  <= h_side_ff.dst_frame;
   end

   // stage v: interpolate, v = s0 * 65536 + (s1 - s0) * f
   logic signed [16:0] v_dl;
   logic signed [16:0] v_dr;
   logic signed [34:0] v_l;
   logic signed [34:0] v_r;
   logic               v_valid_ff;
   logic signed [34:0] v_l_ff;
   logic signed [34:0] v_r_ff;
   logic [23:0]        v_dst_ff;

   assign v_dl = $signed({m_rd1_ff[15], m_rd1_ff[15:0]}) - $signed({m_rd0_ff[15], m_rd0_ff[15:0]});
   assign v_dr = $signed({m_rd1_ff[31], m_rd1_ff[31:16]})
                 - $signed({m_rd0_ff[31], m_rd0_ff[31:16]});
   assign v_l  = $signed({{3{m_rd0_ff[15]}}, m_rd0_ff[15:0], 16'b0})
                 + 35'(v_dl) * 35'($signed({1'b0, m_frac_ff}));
   assign v_r  = $signed({{3{m_rd0_ff[31]}}, m_rd0_ff[31:16], 16'b0})
                 + 35'(v_dr) * 35'($signed({1'b0, m_frac_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else begin
         v_valid_ff <= m_valid_ff;
      end
      v_l_ff   <= v_l;
      v_r_ff   <= v_r;
      v_dst_ff <= m_dst_ff;
   end

   // stage p: gain
   logic               p_valid_ff;
   logic signed [51:0] p_l_ff;
   logic signed [51:0] p_r_ff;
   logic [23:0]        p_dst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= v_valid_ff;
      end
      p_l_ff   <= 52'(v_l_ff) * 52'($signed({1'b0, amplitude_ff}));
      p_r_ff   <= 52'(v_r_ff) * 52'($signed({1'b0, amplitude_ff}));
      p_dst_ff <= v_dst_ff;
   end

   // stage o: round half up, saturate, present result
   function automatic logic signed [15:0] round_sat(input logic signed [51:0] p);
      logic signed [51:0] t;
      logic signed [19:0] r;
      t = p + (52'sd1 <<< 31);
      r = t[51:32];
      if (r > 20'sd32767) begin
         round_sat = 16'sd32767;
      end else if (r < -20'sd32768) begin
         round_sat = -16'sd32768;
      end else begin
         round_sat = r[15:0];
      end
   endfunction

   logic                   rsp_valid_ff;
   glrr_pkg::rsp_item_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_valid_ff;
      end
      rsp_data_ff.out_left      <= round_sat(p_l_ff);
      rsp_data_ff.out_right     <= round_sat(p_r_ff);
      rsp_data_ff.out_dst_frame <= p_dst_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: test/grain_loop_resample_reader_checker.sv
`timescale 1ns / 100ps

module grain_loop_resample_reader_checker #(
   parameter int STORE_FRAMES = 16384
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  glrr_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  glrr_pkg::rsp_item_type rsp_data,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);

   // shadow of the block's registers and frame store
   logic [23:0]        rate_ratio;
   logic [23:0]        loop_window;
   logic signed [23:0] loop_drag;
   logic [31:0]        base_start;
   logic [31:0]        read_start;
   logic [31:0]        total_frames;
   logic [14:0]        frames_loaded;
   logic [15:0]        amplitude;
   logic [31:0]        frame_mem [STORE_FRAMES];

   glrr_pkg::rsp_item_type expected_frames[$];

   initial mismatches = 0;
   initial outstanding = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // blend two samples by a 17-bit fraction, apply gain, round half up, saturate
   function automatic logic signed [15:0] blend_gain(input logic signed [15:0] s0,
                                                     input logic signed [15:0] s1,
                                                     input longint frac);
      longint blended;
      longint scaled;
      longint rounded;
      blended = longint'(s0) * (65536 - frac) + longint'(s1) * frac;
      scaled  = blended * longint'({48'd0, amplitude});
      rounded = ((scaled + (64'sd1 <<< 31) + (64'sd1 <<< 48)) >>> 32) - 65536;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      return rounded[15:0];
   endfunction

   // resample one destination frame from the store
   function automatic glrr_pkg::rsp_item_type render_frame(input logic [23:0] dst);
      glrr_pkg::rsp_item_type res;
      longint unsigned pos;
      longint unsigned ip;
      longint unsigned wraps;
      longint unsigned inwin;
      longint          win_start;
      longint          src;
      longint          local_frame;
      longint          frac;
      longint          store_n;
      longint          i0;
      logic [31:0]     e0;
      logic [31:0]     e1;
      pos = longint'({40'd0, dst}) * longint'({40'd0, rate_ratio});
      ip  = pos >> 16;
      if (loop_window >= 2) begin
         wraps = ip / loop_window;
         inwin = ip % loop_window;
         win_start = longint'({32'd0, base_start}) + longint'(wraps) * longint'(loop_drag);
         if (win_start < 0) win_start = 0;
         if (win_start + longint'({40'd0, loop_window}) >= longint'({32'd0, total_frames})) begin
            win_start = longint'({32'd0, total_frames}) - longint'({40'd0, loop_window}) - 1;
            if (win_start < 0) win_start = 0;
         end
         src = win_start + longint'(inwin);
      end else begin
         src = longint'({32'd0, base_start}) + longint'(ip);
      end
      store_n = longint'({49'd0, frames_loaded});
      if (store_n < 2) store_n = 2;
      if (store_n > STORE_FRAMES) store_n = STORE_FRAMES;
      local_frame = src - longint'({32'd0, read_start});
      if (local_frame < 0) begin
         i0 = 0; frac = 0;
      end else if (local_frame >= store_n - 1) begin
         i0 = store_n - 2; frac = 65536;
      end else begin
         i0 = local_frame; frac = longint'(pos[15:0]);
      end
      e0 = frame_mem[i0];
      e1 = frame_mem[i0 + 1];
      res.out_left      = blend_gain(e0[15:0], e1[15:0], frac);
      res.out_right     = blend_gain(e0[31:16], e1[31:16], frac);
      res.out_dst_frame = dst;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rate_ratio    <= glrr_pkg::RATE_RESET;
         loop_window   <= '0;
         loop_drag     <= '0;
         base_start    <= '0;
         read_start    <= '0;
         total_frames  <= '0;
         frames_loaded <= '0;
         amplitude     <= glrr_pkg::AMP_RESET;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               glrr_pkg::CSR_RATE_RATIO:    rate_ratio    <= csr_wdata[23:0];
               glrr_pkg::CSR_LOOP_WINDOW:   loop_window   <= csr_wdata[23:0];
               glrr_pkg::CSR_LOOP_DRAG:     loop_drag     <= csr_wdata[23:0];
               glrr_pkg::CSR_BASE_START:    base_start    <= csr_wdata;
               glrr_pkg::CSR_READ_START:    read_start    <= csr_wdata;
               glrr_pkg::CSR_TOTAL_FRAMES:  total_frames  <= csr_wdata;
               glrr_pkg::CSR_FRAMES_LOADED: frames_loaded <= csr_wdata[14:0];
               glrr_pkg::CSR_AMPLITUDE:     amplitude     <= csr_wdata[15:0];
               default: ;
            endcase
         end
         // compare result transaction with the oldest prediction
         if (rsp_valid) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected result frame %0d", rsp_data.out_dst_frame));
            end else begin
               glrr_pkg::rsp_item_type want;
               want = expected_frames[0];
               expected_frames.delete(0);
               if (rsp_data.out_dst_frame !== want.out_dst_frame)
                  report_mismatch($sformatf("dst_frame got %0d want %0d",
                                            rsp_data.out_dst_frame, want.out_dst_frame));
               if (rsp_data.out_left !== want.out_left)
                  report_mismatch($sformatf("frame %0d left got %0d want %0d",
                                            want.out_dst_frame, rsp_data.out_left,
                                            want.out_left));
               if (rsp_data.out_right !== want.out_right)
                  report_mismatch($sformatf("frame %0d right got %0d want %0d",
                                            want.out_dst_frame, rsp_data.out_right,
                                            want.out_right));
            end
         end
         // accepted request transaction
         if (start && !busy) begin
            if (req_data.req_type == glrr_pkg::REQ_LOAD) begin
               if (req_data.frame_addr < STORE_FRAMES)
                  frame_mem[req_data.frame_addr] = {req_data.sample_right, req_data.sample_left};
            end else begin
               expected_frames.insert(expected_frames.size(),
                                      render_frame(req_data.dst_frame));
            end
         end
         outstanding = expected_frames.size();
      end
   end

endmodule

// File: test/grain_loop_resample_reader_test.sv
`timescale 1ns / 100ps

module grain_loop_resample_reader_test;

   localparam int STORE_FRAMES = 16384;
   localparam int DRAIN_CYCLES = 50;
   localparam longint CYCLE_LIMIT = 2000000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   glrr_pkg::req_item_type req_data;
   logic                   rsp_valid;
   glrr_pkg::rsp_item_type rsp_data;
   logic                   csr_we;
   logic [2:0]             csr_index;
   logic [31:0]            csr_wdata;
   int                     mismatches;
   int                     outstanding;

   int           idle_pct;
   logic [31:0]  reg_vals [8];
   bit           written [STORE_FRAMES];
   longint       cycle_count;

   grain_loop_resample_reader #(.STORE_FRAMES(STORE_FRAMES)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   grain_loop_resample_reader_checker #(.STORE_FRAMES(STORE_FRAMES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grain_loop_resample_reader: mismatch");
         $finish;
      end
   end

   // hand one transaction to the block, with random idle cycles ahead of it
   task automatic issue(input glrr_pkg::req_item_type it);
      logic was_busy;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      if (it.req_type == glrr_pkg::REQ_LOAD) written[it.frame_addr] = 1'b1;
   endtask

   task automatic load_frame(input logic [13:0] addr, input logic [15:0] l,
                             input logic [15:0] r);
      glrr_pkg::req_item_type it;
      it = '0;
      it.req_type     = glrr_pkg::REQ_LOAD;
      it.frame_addr   = addr;
      it.sample_left  = l;
      it.sample_right = r;
      it.dst_frame    = 24'($urandom());
      issue(it);
   endtask

   task automatic render(input logic [23:0] dst);
      glrr_pkg::req_item_type it;
      it = '0;
      it.req_type  = glrr_pkg::REQ_RENDER;
      it.frame_addr = 14'($urandom());
      it.sample_left  = 16'($urandom());
      it.sample_right = 16'($urandom());
      it.dst_frame = dst;
      issue(it);
   endtask

   // let everything in flight drain, then some extra for loads
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all eight registers from reg_vals, only while idle
   task automatic write_regs();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= reg_vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // fill every store entry that a render may read
   task automatic fill_store(input int count);
      int n;
      n = count < 2 ? 2 : (count > STORE_FRAMES ? STORE_FRAMES : count);
      for (int i = 0; i < n; i++)
         if (!written[i]) load_frame(i[13:0], 16'($urandom()), 16'($urandom()));
   endtask

   task automatic set_regs(input logic [23:0] rate, input logic [23:0] win,
                           input logic [23:0] drag, input logic [31:0] base,
                           input logic [31:0] rd, input logic [31:0] total,
                           input logic [14:0] frames, input logic [15:0] amp);
      drain();
      reg_vals[glrr_pkg::CSR_RATE_RATIO]    = 32'(rate);
      reg_vals[glrr_pkg::CSR_LOOP_WINDOW]   = 32'(win);
      reg_vals[glrr_pkg::CSR_LOOP_DRAG]     = 32'(drag);
      reg_vals[glrr_pkg::CSR_BASE_START]    = base;
      reg_vals[glrr_pkg::CSR_READ_START]    = rd;
      reg_vals[glrr_pkg::CSR_TOTAL_FRAMES]  = total;
      reg_vals[glrr_pkg::CSR_FRAMES_LOADED] = 32'(frames);
      reg_vals[glrr_pkg::CSR_AMPLITUDE]     = 32'(amp);
      write_regs();
      fill_store(int'(frames));
   endtask

   // random render destination: mostly near the start, sometimes anywhere
   function automatic logic [23:0] pick_dst();
      case ($urandom_range(3))
         0: return 24'($urandom());
         1: return 24'($urandom_range(4000));
         default: return 24'($urandom_range(200));
      endcase
   endfunction

   task automatic random_phase(input int items, input int frames);
      logic [31:0] rd;
      logic [31:0] base;
      logic [23:0] rate;
      logic [23:0] win;
      logic [23:0] drag;
      logic [31:0] total;
      rd = $urandom_range(1) ? $urandom() : $urandom_range(50);
      base = rd + $urandom_range(frames) - $urandom_range(3);
      case ($urandom_range(3))
         0: rate = 24'($urandom());
         1: rate = 24'd65536;
         default: rate = 24'($urandom_range(20000, 3000));
      endcase
      case ($urandom_range(3))
         0: win = 24'($urandom_range(1));
         1: win = 24'($urandom());
         default: win = 24'($urandom_range(frames + 2, 2));
      endcase
      drag = $urandom_range(1) ? 24'($urandom()) : 24'($urandom_range(8)) - 24'd4;
      total = $urandom_range(1) ? $urandom() : base + $urandom_range(frames + 10);
      set_regs(rate, win, drag, base, rd, total, 15'(frames), 16'($urandom()));
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(4) == 0) begin
            logic [15:0] l;
            l = 16'($urandom());
            // mono sources carry the left sample on both sides
            load_frame($urandom_range(3) == 0 ? 14'($urandom()) : 14'($urandom_range(frames)),
                       l, $urandom_range(1) ? l : 16'($urandom()));
         end else begin
            render(pick_dst());
         end
      end
   endtask

   // loaded count above the store size: renders stay near the start or past the end
   task automatic clamp_phase(input int items);
      set_regs(24'd65536, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 15'd64, 16'($urandom()));
      load_frame(14'd16382, 16'($urandom()), 16'($urandom()));
      load_frame(14'd16383, 16'($urandom()), 16'($urandom()));
      drain();
      reg_vals[glrr_pkg::CSR_FRAMES_LOADED] = 32'd32767;
      write_regs();
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(1) == 0) begin
            render(24'($urandom_range(60)));
         end else begin
            render(24'($urandom_range(32'hFFFFFF, 16383)));
         end
      end
   endtask

   initial begin
      int phase_idle [4];
      phase_idle = '{0, 77, 0, 29};
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: sample extremes, past and before the store, defaults
      load_frame(14'd0, 16'h7FFF, 16'h8000);
      load_frame(14'd1, 16'h8000, 16'h7FFF);
      load_frame(14'd2, 16'h1234, 16'h1234);
      load_frame(14'd3, 16'hFFFF, 16'h0001);
      load_frame(14'd16383, 16'h5555, 16'hAAAA);
      set_regs(24'd65536, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 15'd4, 16'hFFFF);
      render(24'd0); render(24'd1); render(24'd2); render(24'd10); render(24'hFFFFFF);
      // fraction with full gain, zero gain
      set_regs(24'd32768, 24'd1, 24'd0, 32'd0, 32'd0, 32'd0, 15'd4, 16'hFFFF);
      render(24'd1); render(24'd3); render(24'd5);
      set_regs(24'hFFFFFF, 24'd0, 24'd0, 32'd0, 32'd0, 32'd0, 15'd0, 16'd0);
      render(24'd0); render(24'hFFFFFF);
      // store starts after the position
      set_regs(24'd65536, 24'd0, 24'd0, 32'd0, 32'd100, 32'd0, 15'd1, 16'd32768);
      render(24'd5);
      // zero rate always reads the grain start
      set_regs(24'd0, 24'd0, 24'd0, 32'd2, 32'd0, 32'd0, 15'd4, 16'd40000);
      render(24'd7); render(24'hFFFFFF);
      // loop with window start dragged negative
      set_regs(24'd65536, 24'd2, 24'h800000, 32'd1, 32'd0, 32'hFFFFFFFF, 15'd4, 16'hFFFF);
      render(24'd1); render(24'd2); render(24'd5);
      // loop window pushed back inside a short file
      set_regs(24'd98304, 24'd3, 24'h7FFFFF, 32'hFFFFFFFF, 32'd0, 32'd5, 15'd4, 16'hFFFF);
      render(24'd1); render(24'd4); render(24'd9);
      set_regs(24'd65536, 24'hFFFFFF, 24'd1, 32'd0, 32'd0, 32'd0, 15'd4, 16'd1);
      render(24'd3); render(24'hFFFFFF);

      // random phases, cycling the idle pattern
      for (int p = 0; p < 8; p++) begin
         idle_pct = phase_idle[p % 4];
         random_phase(130, $urandom_range(1) ? $urandom_range(64, 2) : $urandom_range(600, 2));
      end
      // loaded count clamped from above
      idle_pct = 0;
      clamp_phase(120);

      drain();
      if (mismatches == 0) begin
         $display("grain_loop_resample_reader: match");
      end else begin
         $display("grain_loop_resample_reader: mismatch");
      end
      $finish;
   end

endmodule

// File: grain_loop_resample_reader.f
hdl/glrr_pkg.sv
hdl/glrr_div.sv
hdl/grain_loop_resample_reader.sv
test/grain_loop_resample_reader_checker.sv
test/grain_loop_resample_reader_test.sv
